>>> rtl/artc_pkg.sv
// Shared types and constants for the audit rule table classifier.
package artc_pkg;

  localparam int unsigned MaxRulesDefault = 16;

  typedef enum logic [1:0] {
    KIND_EVAL   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_ENABLE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FLD_TYPE    = 3'd0,
    FLD_UID     = 3'd1,
    FLD_PID     = 3'd2,
    FLD_SYSCALL = 3'd3,
    FLD_RESULT  = 3'd4
  } field_e;

  // One accepted transaction as it waits between the front and the back part.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] target_id;
    logic [2:0]  filter_field;
    logic [31:0] criterion;
    logic [1:0]  rule_action;
    logic        enable_flag;
    logic [15:0] event_code;
    logic [31:0] event_uid;
    logic [31:0] event_pid;
    logic [15:0] event_syscall;
    logic [7:0]  event_result;
  } cmd_t;

  // One rule of the table.
  typedef struct packed {
    logic [31:0] id;
    logic [2:0]  field;
    logic [31:0] value;
    logic [1:0]  action;
    logic        enable;
  } rule_t;

endpackage

>>> rtl/audit_rule_table_classifier.sv
// Top level of the audit rule table classifier.
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | kind_i .. event_result_i
//  out     | output    | out_valid_o / out_ready_i | status_o .. visits_total_o
// A transaction enters the two-entry queue in the cycle it is accepted and is
// executed by the back part once it is registered in the queue and reaches
// its head; one transaction per cycle is sustained while the output is taken,
// set by the parallel rule compare and table update in the back part.
// Reset (rst_ni low) empties the table and queue and sets the id counter to one.
// A stalled output holds its result; the queue keeps accepting until full.
module audit_rule_table_classifier import artc_pkg::*; #(
  parameter int unsigned MaxRules = MaxRulesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] target_id_i,
  input  logic [2:0]  filter_field_i,
  input  logic [31:0] criterion_i,
  input  logic [1:0]  rule_action_i,
  input  logic        enable_flag_i,
  input  logic [15:0] event_code_i,
  input  logic [31:0] event_uid_i,
  input  logic [31:0] event_pid_i,
  input  logic [15:0] event_syscall_i,
  input  logic [7:0]  event_result_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  chosen_action_o,
  output logic [31:0] given_id_o,
  output logic [4:0]  rules_held_o,
  output logic [63:0] visits_total_o
);

  cmd_t cmd, q_cmd;
  logic q_valid, q_ready;

  // Gather the input fields into one transaction record.
  assign cmd = '{kind: kind_e'(kind_i), target_id: target_id_i,
                 filter_field: filter_field_i, criterion: criterion_i,
                 rule_action: rule_action_i, enable_flag: enable_flag_i,
                 event_code: event_code_i, event_uid: event_uid_i,
                 event_pid: event_pid_i, event_syscall: event_syscall_i,
                 event_result: event_result_i};

  artc_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i(cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  artc_back #(.MaxRules(MaxRules)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .status_o, .chosen_action_o, .given_id_o,
    .rules_held_o, .visits_total_o
  );

endmodule

>>> rtl/artc_front.sv
// Front part: accepts transactions and holds them in a short queue.
module artc_front import artc_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t cmd_i,
  output logic q_valid_o,
  input  logic q_ready_i,
  output cmd_t q_cmd_o
);

  localparam int unsigned PtrW = $clog2(Depth);

  cmd_t              mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              push, pop;

  assign in_ready_o = (cnt_q != (PtrW+1)'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_cmd_o    = mem_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

>>> rtl/artc_back.sv
// Back part: rule table, id search, shift on delete, priority evaluation.
module artc_back import artc_pkg::*; #(
  parameter int unsigned MaxRules = MaxRulesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  cmd_t        q_cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  chosen_action_o,
  output logic [31:0] given_id_o,
  output logic [4:0]  rules_held_o,
  output logic [63:0] visits_total_o
);

  localparam int unsigned IdxW = $clog2(MaxRules);
  localparam int unsigned OccW = $clog2(MaxRules + 1);

  rule_t           rules_q [MaxRules];
  logic [OccW-1:0] occ_q, occ_d;
  logic [31:0]     id_ctr_q, id_ctr_d;
  logic [63:0]     visits_q, visits_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      status_q, status_d;
  logic [1:0]      action_q, action_d;
  logic [31:0]     given_q, given_d;

  logic [MaxRules-1:0] hit, idm;
  logic [IdxW-1:0]     hit_idx, id_idx;
  logic                any_hit, any_id;
  logic [31:0]         ev [5];
  logic                take, full;
  logic [31:0]         new_id;

  assign q_ready_o = !out_valid_q || out_ready_i;
  assign take      = q_valid_i && q_ready_o;
  assign full      = (occ_q >= OccW'(MaxRules));
  assign new_id    = (q_cmd_i.target_id == '0) ? id_ctr_q : q_cmd_i.target_id;

  // The table and counters only change when a result is produced, so the
  // live counters are exactly what the held result reports.
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign chosen_action_o = action_q;
  assign given_id_o      = given_q;
  assign rules_held_o    = 5'(occ_q);
  assign visits_total_o  = visits_q;

  assign ev[0] = {16'd0, q_cmd_i.event_code};
  assign ev[1] = q_cmd_i.event_uid;
  assign ev[2] = q_cmd_i.event_pid;
  assign ev[3] = {16'd0, q_cmd_i.event_syscall};
  assign ev[4] = {24'd0, q_cmd_i.event_result};

  // Per-rule compares run in parallel; lanes are independent.
  always_comb begin
    for (int s = 0; s < MaxRules; s++) begin
      logic live;
      live   = (OccW'(s) < occ_q);
      hit[s] = live && rules_q[s].enable && (rules_q[s].field <= FLD_RESULT) &&
               (ev[rules_q[s].field[2:0] > FLD_RESULT ? 3'd0 : rules_q[s].field]
                == rules_q[s].value);
      idm[s] = live && (rules_q[s].id == q_cmd_i.target_id);
    end
  end

  // Lowest index hit (oldest) and highest index id match (newest).
  always_comb begin
    hit_idx = '0;
    any_hit = 1'b0;
    id_idx  = '0;
    any_id  = 1'b0;
    for (int s = MaxRules - 1; s >= 0; s--) begin
      if (hit[s]) begin
        hit_idx = IdxW'(s);
        any_hit = 1'b1;
      end
    end
    for (int s = 0; s < MaxRules; s++) begin
      if (idm[s]) begin
        id_idx = IdxW'(s);
        any_id = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      case (q_cmd_i.kind)
        KIND_ADD: begin
          if (!full) begin
            rules_q[occ_q[IdxW-1:0]] <= '{id: new_id, field: q_cmd_i.filter_field,
                                          value: q_cmd_i.criterion,
                                          action: q_cmd_i.rule_action,
                                          enable: q_cmd_i.enable_flag};
          end
        end
        KIND_DELETE: begin
          if (any_id) begin
            for (int s = 0; s < MaxRules - 1; s++) begin
              if (IdxW'(s) >= id_idx) begin
                rules_q[s] <= rules_q[s+1];
              end
            end
          end
        end
        KIND_ENABLE: begin
          if (any_id) begin
            rules_q[id_idx].enable <= q_cmd_i.enable_flag;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    occ_d       = occ_q;
    id_ctr_d    = id_ctr_q;
    visits_d    = visits_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    action_d    = action_q;
    given_d     = given_q;
    if (take) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      action_d    = '0;
      given_d     = '0;
      case (q_cmd_i.kind)
        KIND_EVAL: begin
          if (any_hit) begin
            action_d = rules_q[hit_idx].action;
          end
          visits_d = visits_q + 64'(occ_q);
        end
        KIND_ADD: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            occ_d   = occ_q + 1'b1;
            given_d = new_id;
            if (q_cmd_i.target_id == '0) begin
              id_ctr_d = id_ctr_q + 32'd1;
            end
          end
        end
        KIND_DELETE: begin
          if (any_id) begin
            occ_d = occ_q - 1'b1;
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        KIND_ENABLE: begin
          if (!any_id) begin
            status_d = ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      id_ctr_q    <= 32'd1;
      visits_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      action_q    <= '0;
      given_q     <= '0;
    end else begin
      occ_q       <= occ_d;
      id_ctr_q    <= id_ctr_d;
      visits_q    <= visits_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      action_q    <= action_d;
      given_q     <= given_d;
    end
  end

endmodule

>>> rtl/artc_checker.sv
// Port-level checks for the audit rule table classifier.
module artc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [1:0]  chosen_action_o,
  input logic [31:0] given_id_o,
  input logic [4:0]  rules_held_o,
  input logic [63:0] visits_total_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(given_id_o))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status");

  a_full_noid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 2'd0 |-> given_id_o == '0 && chosen_action_o == '0)
    else $error("failed op carries payload");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rules_held_o <= 5'd16)
    else $error("occupancy out of range");

endmodule

bind audit_rule_table_classifier artc_checker u_artc_checker (.*);

>>> bench/artc_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the rule table's results and compares them with the block.
module tb_artc_checker import artc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] target_id_i,
  input  logic [2:0]  filter_field_i,
  input  logic [31:0] criterion_i,
  input  logic [1:0]  rule_action_i,
  input  logic        enable_flag_i,
  input  logic [15:0] event_code_i,
  input  logic [31:0] event_uid_i,
  input  logic [31:0] event_pid_i,
  input  logic [15:0] event_syscall_i,
  input  logic [7:0]  event_result_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [1:0]  chosen_action_i,
  input  logic [31:0] given_id_i,
  input  logic [4:0]  rules_held_i,
  input  logic [63:0] visits_total_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          outcomes_seen_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  action;
    logic [31:0] given;
    logic [4:0]  held;
    logic [63:0] visits;
  } outcome_t;

  rule_t       rules[MaxRulesDefault];
  int unsigned held;
  logic [31:0] next_id;
  logic [63:0] visits;
  outcome_t    outcome_q[$];

  assign pending_o = outcome_q.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  function automatic int newest_with_id(input logic [31:0] id);
    for (int i = int'(held) - 1; i >= 0; i--)
      if (rules[i].id == id) return i;
    return -1;
  endfunction

  task automatic classify_transaction();
    outcome_t    o;
    logic [31:0] ev[5];
    int          pos;
    o = '0;
    case (kind_e'(kind_i))
      KIND_EVAL: begin
        ev[0] = {16'd0, event_code_i};
        ev[1] = event_uid_i;
        ev[2] = event_pid_i;
        ev[3] = {16'd0, event_syscall_i};
        ev[4] = {24'd0, event_result_i};
        for (int s = 0; s < int'(held); s++) begin
          if (rules[s].enable && rules[s].field <= FLD_RESULT &&
              ev[rules[s].field] == rules[s].value) begin
            o.action = rules[s].action;
            break;
          end
        end
        visits += 64'(held);
      end
      KIND_ADD: begin
        if (held >= MaxRulesDefault) begin
          o.status = ST_FULL;
        end else begin
          o.given = target_id_i;
          if (target_id_i == 0) begin
            o.given = next_id;
            next_id++;
          end
          rules[held] = '{o.given, filter_field_i, criterion_i, rule_action_i,
                          enable_flag_i};
          held++;
        end
      end
      KIND_DELETE: begin
        pos = newest_with_id(target_id_i);
        if (pos < 0) begin
          o.status = ST_NOT_FOUND;
        end else begin
          for (int s = pos; s + 1 < int'(held); s++) rules[s] = rules[s + 1];
          held--;
        end
      end
      default: begin
        pos = newest_with_id(target_id_i);
        if (pos < 0) o.status = ST_NOT_FOUND;
        else rules[pos].enable = enable_flag_i;
      end
    endcase
    o.held = held[4:0];
    o.visits = visits;
    outcome_q.push_back(o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t w;
    if (!rst_ni) begin
      held = 0;
      next_id = 1;
      visits = '0;
      outcome_q.delete();
      fail_count_o = 0;
      outcomes_seen_o = 0;
    end else begin
      // Results are checked before the new transaction is predicted; the
      // block cannot emit a result in the cycle its transaction enters.
      if (out_valid_i && out_ready_i) begin
        outcomes_seen_o++;
        if (outcome_q.size() == 0) begin
          $display("result with nothing expected at %0t", $time);
          fail_count_o++;
        end else begin
          w = outcome_q.pop_front();
          if (status_i !== w.status)
            report_mismatch("status", 64'(status_i), 64'(w.status));
          if (chosen_action_i !== w.action)
            report_mismatch("chosen_action", 64'(chosen_action_i), 64'(w.action));
          if (given_id_i !== w.given)
            report_mismatch("given_id", 64'(given_id_i), 64'(w.given));
          if (rules_held_i !== w.held)
            report_mismatch("rules_held", 64'(rules_held_i), 64'(w.held));
          if (visits_total_i !== w.visits)
            report_mismatch("visits_total", visits_total_i, w.visits);
        end
      end
      if (in_valid_i && in_ready_i) classify_transaction();
    end
  end

endmodule

>>> bench/tb_audit_rule_table_classifier.sv
`timescale 1ns / 1ps
// Testbench top for the audit rule table classifier: stimulus and verdict.
module tb_audit_rule_table_classifier import artc_pkg::*;;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_EVAL;
  logic [31:0] target_id_i = '0;
  logic [2:0]  filter_field_i = '0;
  logic [31:0] criterion_i = '0;
  logic [1:0]  rule_action_i = '0;
  logic        enable_flag_i = 1'b0;
  logic [15:0] event_code_i = '0;
  logic [31:0] event_uid_i = '0;
  logic [31:0] event_pid_i = '0;
  logic [15:0] event_syscall_i = '0;
  logic [7:0]  event_result_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [1:0]  chosen_action_o;
  logic [31:0] given_id_o;
  logic [4:0]  rules_held_o;
  logic [63:0] visits_total_o;
  int          fail_count;
  int          pending;
  int          outcomes_seen;

  // Idling percentages for sender and receiver, and the receiver hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  bit          hold_off = 1'b0;

  // Ids recently handed out, so deletes and enables mostly hit real rules.
  logic [31:0] known_ids[$];

  always #5 clk_i = ~clk_i;

  audit_rule_table_classifier dut (.*);

  tb_artc_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .target_id_i,
    .filter_field_i, .criterion_i, .rule_action_i, .enable_flag_i, .event_code_i,
    .event_uid_i, .event_pid_i, .event_syscall_i, .event_result_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .chosen_action_i(chosen_action_o), .given_id_i(given_id_o),
    .rules_held_i(rules_held_o), .visits_total_i(visits_total_o),
    .fail_count_o(fail_count), .pending_o(pending), .outcomes_seen_o(outcomes_seen)
  );

  // The receiver takes results at random, except during a hold-off.
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= take_idle_pct);
  end

  // Watch given ids as results come back, so later commands can name them.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i && given_id_o != 0) begin
      known_ids.push_back(given_id_o);
      if (known_ids.size() > 24) void'(known_ids.pop_front());
    end
  end

  // Present one transaction and wait until it is accepted. A random gap comes
  // first, with valid low.
  task automatic send_transaction(input kind_e k, input logic [31:0] id,
                                  input logic [2:0] fld, input logic [31:0] crit,
                                  input logic [1:0] act, input logic en,
                                  input logic [15:0] ty, input logic [31:0] uid,
                                  input logic [31:0] pid, input logic [15:0] sc,
                                  input logic [7:0] res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= k;
    target_id_i     <= id;
    filter_field_i  <= fld;
    criterion_i     <= crit;
    rule_action_i   <= act;
    enable_flag_i   <= en;
    event_code_i    <= ty;
    event_uid_i     <= uid;
    event_pid_i     <= pid;
    event_syscall_i <= sc;
    event_result_i  <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pick an id for delete or enable: usually one handed out lately, sometimes anything.
  function automatic logic [31:0] pick_id();
    if (known_ids.size() > 0 && $urandom_range(9) < 8)
      return known_ids[$urandom_range(known_ids.size() - 1)];
    return ($urandom_range(1)) ? $urandom : $urandom_range(20);
  endfunction

  // A random transaction. Criteria are drawn small often so that event fields
  // drawn from the same small range actually hit rules.
  task automatic random_transaction();
    int unsigned r;
    logic [31:0] crit;
    r = $urandom_range(99);
    crit = ($urandom_range(2) == 0) ? $urandom : $urandom_range(7);
    if (r < 45)
      send_transaction(KIND_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom,
                       ($urandom_range(3) == 0) ? $urandom : $urandom_range(7),
                       ($urandom_range(3) == 0) ? $urandom : $urandom_range(7),
                       ($urandom_range(3) == 0) ? $urandom : $urandom_range(7),
                       ($urandom_range(3) == 0) ? $urandom : $urandom_range(7),
                       ($urandom_range(3) == 0) ? $urandom : $urandom_range(7));
    else if (r < 70)
      send_transaction(KIND_ADD, ($urandom_range(1)) ? 32'd0 : $urandom_range(20),
                       $urandom, crit, $urandom, $urandom_range(7) != 0,
                       $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (r < 85)
      send_transaction(KIND_DELETE, pick_id(), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      send_transaction(KIND_ENABLE, pick_id(), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Fill the table with one rule per field, including a
    // criterion beyond its field's width, a never-matching field and action
    // code three, then overflow it.
    send_transaction(KIND_EVAL, '0, '0, '0, '0, '0, 16'hFFFF, '1, '1, 16'hFFFF, 8'hFF);
    send_transaction(KIND_ADD, '0, FLD_TYPE, 32'h0001_FFFF, 2'd1, 1'b1, '0, '0, '0, '0, '0);
    send_transaction(KIND_ADD, '0, FLD_UID, '1, 2'd2, 1'b1, '0, '0, '0, '0, '0);
    send_transaction(KIND_ADD, '1, FLD_PID, '1, 2'd3, 1'b1, '0, '0, '0, '0, '0);
    send_transaction(KIND_ADD, 32'd7, FLD_SYSCALL, 32'hFFFF, 2'd1, 1'b1, '0, '0, '0, '0, '0);
    send_transaction(KIND_ADD, 32'd7, FLD_RESULT, 32'hFF, 2'd2, 1'b0, '0, '0, '0, '0, '0);
    send_transaction(KIND_ADD, '0, 3'd7, '0, 2'd1, 1'b1, '0, '0, '0, '0, '0);
    send_transaction(KIND_EVAL, '0, '0, '0, '0, '0, 16'hFFFF, '1, '1, 16'hFFFF, 8'hFF);
    send_transaction(KIND_EVAL, '0, '0, '0, '0, '0, '0, '0, '1, 16'hFFFF, 8'hFF);
    // Newest rule with id seven is the disabled result rule: enable it.
    send_transaction(KIND_ENABLE, 32'd7, '0, '0, '0, 1'b1, '0, '0, '0, '0, '0);
    send_transaction(KIND_EVAL, '0, '0, '0, '0, '0, '0, '0, '0, '0, 8'hFF);
    send_transaction(KIND_DELETE, 32'd7, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    send_transaction(KIND_DELETE, 32'd12345, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    send_transaction(KIND_ENABLE, 32'd12345, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);
    for (int i = 0; i < 12; i++)
      send_transaction(KIND_ADD, '0, 3'(i), 32'(i), 2'(i), 1'(i), '0, '0, '0, '0, '0);
    send_transaction(KIND_EVAL, '0, '0, '0, '0, '0, 16'd3, 32'd1, 32'd2, 16'd3, 8'd4);
    wait_drained();

    // Random part in three idling regimes; random deletes among the transactions
    // free table slots so that some later adds succeed.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 58 : 0;
      take_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 13 : 0;
      for (int n = 0; n < 230; n++) begin
        // Long receiver hold-off while items keep coming, so the queue fills.
        if (phase == 2 && n == 50) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (40) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        random_transaction();
      end
      wait_drained();
    end
    go_idle();

    repeat (20) @(posedge clk_i);
    $display("Covered %0d results: evaluations, adds with auto and given ids,", outcomes_seen);
    $display("deletes, enables, full table, missing ids and three idling regimes.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/artc_pkg.sv
rtl/artc_front.sv
rtl/artc_back.sv
rtl/audit_rule_table_classifier.sv
rtl/artc_checker.sv
bench/artc_checker.sv
bench/tb_audit_rule_table_classifier.sv
